/* design/gha_pkg.sv */
// Package: types, codes and helpers shared by the handle allocator files.
`timescale 1ns / 1ps
`default_nettype none
package gha_pkg;

  localparam int SLOTS  = 1024;
  localparam int IDX_W  = 10;
  localparam int GEN_W  = 16;
  localparam int CNT_W  = 10;
  localparam int FRESH_W = IDX_W + 1;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  localparam logic [GEN_W-1:0] GEN_FIRST  = GEN_W'(1);
  localparam logic [GEN_W-1:0] GEN_PINNED = '1;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] out_index;
    logic [GEN_W-1:0] out_generation;
    logic             alive;
    logic [CNT_W-1:0] live_count;
  } out_item_t;

  // One slot entry: live mark, generation and free-list link.
  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] link;
  } slot_entry_t;

  // Generation bump; a wrap to zero is pinned at the top value.
  function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    bump_gen = (n == '0) ? GEN_PINNED : n;
  endfunction

endpackage
`default_nettype wire

/* design/gha_slot_ram.sv */
// Slot table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gha_slot_ram
  import gha_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire slot_entry_t      wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output slot_entry_t           rd_data
);

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* design/generational_handle_allocator.sv */
// Top level: command sequencer around the slot table memory.
// Create, destroy and query: the slot is read at the accept edge and, for create and
// destroy, modified and written back at the next; the result strobe follows that edge.
// Clear walks slots 1 .. fresh_r-1, reading each slot and then writing it back if live.
// A new item is accepted only while idle, after the read-modify-write of the last one.
// Results cannot be stalled. Synchronous active-low reset empties the free list and
// the table; slots at or past the fresh pointer are never used, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_allocator
  import gha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_CLR_RD = 2'd2;
  localparam logic [1:0] S_CLR_WR = 2'd3;

  logic [1:0]         state_r, state_nxt;
  in_item_t           cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [FRESH_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [FRESH_W-1:0] walk_r, walk_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  slot_entry_t        wr_data;
  logic [IDX_W-1:0]   rd_addr;
  slot_entry_t        rd_data;

  logic               accept;
  logic               idx_valid;
  logic               match;

  gha_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign idx_valid = (cmd_r.slot_index != '0) &&
                     ({1'b0, cmd_r.slot_index} < fresh_r);
  assign match     = idx_valid && rd_data.live &&
                     (rd_data.gen == cmd_r.handle_generation);

  always_comb begin
    rd_addr = (in_item.command == CMD_CREATE) ? head_r : in_item.slot_index;
    if (state_r == S_CLR_RD) begin
      rd_addr = walk_r[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    fresh_nxt     = fresh_r;
    live_nxt      = live_r;
    walk_nxt      = walk_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = cmd_r.slot_index;
    wr_data       = '{live: 1'b0, gen: bump_gen(rd_data.gen), link: head_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_item;
          walk_nxt = FRESH_W'(1);
          state_nxt = (in_item.command == CMD_CLEAR) ? S_CLR_RD : S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        case (cmd_r.command)
          CMD_CREATE: begin
            if (head_r != '0) begin
              wr_en    = 1'b1;
              wr_addr  = head_r;
              wr_data  = '{live: 1'b1, gen: rd_data.gen, link: rd_data.link};
              head_nxt = rd_data.link;
              live_nxt = live_r + CNT_W'(1);
              out_nxt.out_index      = head_r;
              out_nxt.out_generation = rd_data.gen;
            end else if (fresh_r < FRESH_W'(SLOTS)) begin
              wr_en     = 1'b1;
              wr_addr   = fresh_r[IDX_W-1:0];
              wr_data   = '{live: 1'b1, gen: GEN_FIRST, link: '0};
              fresh_nxt = fresh_r + FRESH_W'(1);
              live_nxt  = live_r + CNT_W'(1);
              out_nxt.out_index      = fresh_r[IDX_W-1:0];
              out_nxt.out_generation = GEN_FIRST;
            end else begin
              out_nxt.status = STAT_FULL;
            end
          end
          CMD_DESTROY: begin
            if (match) begin
              wr_en    = 1'b1;
              head_nxt = cmd_r.slot_index;
              if (live_r != '0) begin
                live_nxt = live_r - CNT_W'(1);
              end
            end else begin
              out_nxt.status = STAT_IGNORED;
            end
          end
          CMD_QUERY: begin
            out_nxt.alive = match;
          end
          default: ;
        endcase
        out_nxt.live_count = live_nxt;
        state_nxt = S_IDLE;
      end
      S_CLR_RD: begin
        state_nxt = S_CLR_WR;
      end
      S_CLR_WR: begin
        // rd_data holds the slot at walk_r; entries at or past fresh are never valid
        if (rd_data.live && (walk_r < fresh_r)) begin
          wr_en    = 1'b1;
          wr_addr  = walk_r[IDX_W-1:0];
          head_nxt = walk_r[IDX_W-1:0];
        end
        walk_nxt = walk_r + FRESH_W'(1);
        if (walk_nxt >= fresh_r) begin
          live_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CLR_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fresh_r     <= FRESH_W'(1);
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fresh_r     <= fresh_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    walk_r <= walk_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

/* design/gha_checker.sv */
// Port-level checks for the handle allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gha_checker
  import gha_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != STAT_DONE) |->
      (out_item.out_index == '0) && (out_item.out_generation == '0) && !out_item.alive)
    else $error("failed command carries handle data");

  a_alive_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.alive |-> (out_item.status == STAT_DONE) &&
      (out_item.live_count != '0) && (out_item.out_index == '0))
    else $error("alive reported with inconsistent fields");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

/* test/testbench.sv */
// Testbench for the generational handle allocator: directed, slot-recycle, full-table and random runs.
`timescale 1ns / 1ps
module testbench;
  import gha_pkg::*;

  localparam int CYCLE_LIMIT = 16_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  cmd_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t reply_item;

  // Shadow copy of the slot table and allocator registers
  bit [GEN_W-1:0] slot_gen [SLOTS];
  bit             slot_live [SLOTS];
  int             slot_link [SLOTS];
  int             head_slot = 0;
  int             fresh_slot = 1;
  int             live_cnt = 0;

  out_item_t handle_replies [$];
  out_item_t last_reply;
  int        bad_count = 0;

  generational_handle_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (cmd_item),
    .out_valid (out_valid),
    .out_item  (reply_item)
  );

  always #5 clk = ~clk;

  function automatic in_item_t mk_item(logic [1:0] c, logic [IDX_W-1:0] s,
                                       logic [GEN_W-1:0] g);
    in_item_t it;
    it.command = c;
    it.slot_index = s;
    it.handle_generation = g;
    return it;
  endfunction

  // Kill a slot, bump its generation (held at the top once there) and push it on the free list
  function automatic void retire_slot(int s);
    slot_live[s] = 1'b0;
    if (slot_gen[s] != GEN_PINNED) slot_gen[s] = slot_gen[s] + GEN_W'(1);
    slot_link[s] = head_slot;
    head_slot = s;
  endfunction

  function automatic out_item_t apply_handle_cmd(in_item_t it);
    out_item_t r;
    int s;
    bit hit;
    r = '0;
    s = int'(it.slot_index);
    hit = s != 0 && s < fresh_slot && slot_live[s] && slot_gen[s] == it.handle_generation;
    case (it.command)
      CMD_CREATE: begin
        s = 0;
        if (head_slot != 0) begin
          s = head_slot;
          head_slot = slot_link[s];
        end else if (fresh_slot < SLOTS) begin
          s = fresh_slot;
          fresh_slot++;
          slot_gen[s] = GEN_FIRST;
        end
        if (s != 0) begin
          slot_live[s] = 1'b1;
          live_cnt++;
          r.out_index = IDX_W'(s);
          r.out_generation = slot_gen[s];
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_DESTROY: begin
        if (hit) begin
          retire_slot(s);
          live_cnt--;
        end else begin
          r.status = STAT_IGNORED;
        end
      end
      CMD_QUERY: r.alive = hit;
      default: begin
        for (int i = 1; i < fresh_slot; i++)
          if (slot_live[i]) retire_slot(i);
        live_cnt = 0;
      end
    endcase
    r.live_count = CNT_W'(live_cnt);
    return r;
  endfunction

  function automatic int pick_live_slot();
    int top, s;
    top = fresh_slot - 1;
    if (top < 1 || live_cnt == 0) return 0;
    s = $urandom_range(top, 1);
    repeat (top) begin
      if (slot_live[s]) return s;
      s = (s == top) ? 1 : s + 1;
    end
    return 0;
  endfunction

  // Mostly well-formed handles, some stale or off-by-one generations, some noise
  function automatic in_item_t random_handle_cmd();
    in_item_t it;
    int k, s;
    k = $urandom_range(99, 0);
    it = mk_item(CMD_CREATE, IDX_W'($urandom), GEN_W'($urandom));
    s = pick_live_slot();
    if (k >= 35 && k < 88) begin
      it.command = (k < 68) ? CMD_DESTROY : CMD_QUERY;
      if (k < 60 || (k >= 68 && k < 78)) begin
        if (s != 0) begin
          it.slot_index = IDX_W'(s);
          it.handle_generation = slot_gen[s];
        end
      end else if (fresh_slot > 1) begin
        s = $urandom_range(fresh_slot - 1, 1);
        it.slot_index = IDX_W'(s);
        it.handle_generation = slot_gen[s] + GEN_W'($urandom_range(2, 0)) - GEN_W'(1);
      end
    end else if (k >= 88 && k < 91) begin
      it.command = CMD_CLEAR;
    end else if (k >= 91) begin
      it.command = 2'($urandom);
    end
    return it;
  endfunction

  task automatic issue_cmd(input in_item_t it);
    start <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    last_reply = apply_handle_cmd(it);
    handle_replies = {handle_replies, last_reply};
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (handle_replies.size() != 0);
  endtask

  task automatic test_directed_cases();
    issue_cmd(mk_item(CMD_QUERY, '0, '0));
    issue_cmd(mk_item(CMD_DESTROY, '0, '0));
    issue_cmd(mk_item(CMD_DESTROY, '1, '1));       // beyond the used slots
    issue_cmd(mk_item(CMD_CLEAR, '0, '0));         // clear of an empty table
    issue_cmd(mk_item(CMD_CREATE, '1, '1));
    issue_cmd(mk_item(CMD_CREATE, '0, '0));
    issue_cmd(mk_item(CMD_QUERY, IDX_W'(1), GEN_W'(1)));
    issue_cmd(mk_item(CMD_QUERY, IDX_W'(1), GEN_W'(2)));
    issue_cmd(mk_item(CMD_DESTROY, IDX_W'(1), GEN_W'(2)));
    issue_cmd(mk_item(CMD_DESTROY, IDX_W'(1), GEN_W'(1)));
    issue_cmd(mk_item(CMD_DESTROY, IDX_W'(1), GEN_W'(1)));  // already dead
    issue_cmd(mk_item(CMD_QUERY, IDX_W'(1), GEN_W'(1)));
    issue_cmd(mk_item(CMD_CREATE, '0, '0));        // reuses slot 1 at gen 2
    issue_cmd(mk_item(CMD_CREATE, '0, '0));
    issue_cmd(mk_item(CMD_CLEAR, '1, '1));
    issue_cmd(mk_item(CMD_CREATE, '0, '0));        // LIFO: last slot pushed by clear
    issue_cmd(mk_item(CMD_QUERY, IDX_W'(3), GEN_W'(2)));
    issue_cmd(mk_item(CMD_DESTROY, IDX_W'(3), GEN_W'(2)));
    issue_cmd(mk_item(CMD_QUERY, IDX_W'(3), '1));
    issue_cmd(mk_item(CMD_QUERY, '1, GEN_W'(16'h8000)));
    drain_replies();
  endtask

  // Hand the same slot out again and again, retiring it by destroy and now and then by clear;
  // the LIFO free list keeps returning that one slot with a rising generation
  task automatic test_slot_recycle();
    int n;
    bit by_clear;
    issue_cmd(mk_item(CMD_CLEAR, '0, '0));
    for (n = 0; n < 16; n++) begin
      issue_cmd(mk_item(CMD_CREATE, IDX_W'($urandom), GEN_W'($urandom)));
      by_clear = (n % 4 == 3);
      if (by_clear)
        issue_cmd(mk_item(CMD_CLEAR, IDX_W'($urandom), GEN_W'($urandom)));
      else
        issue_cmd(mk_item(CMD_DESTROY, last_reply.out_index, last_reply.out_generation));
    end
    issue_cmd(mk_item(CMD_CREATE, '0, '0));
    issue_cmd(mk_item(CMD_QUERY, last_reply.out_index, GEN_PINNED));
    issue_cmd(mk_item(CMD_DESTROY, last_reply.out_index, '0));
    drain_replies();
  endtask

  task automatic test_random_mix(input int n_items, input bit with_idle);
    for (int k = 0; k < n_items; k++) begin
      if (with_idle && $urandom_range(5, 0) == 0) idle_burst($urandom_range(17, 1));
      issue_cmd(random_handle_cmd());
    end
    drain_replies();
  endtask

  task automatic test_table_full();
    int s;
    logic [GEN_W-1:0] g;
    while (head_slot != 0 || fresh_slot < SLOTS) begin
      if ($urandom_range(7, 0) == 0) idle_burst($urandom_range(17, 1));
      issue_cmd(mk_item(CMD_CREATE, IDX_W'($urandom), GEN_W'($urandom)));
    end
    repeat (2) issue_cmd(mk_item(CMD_CREATE, '0, '0));
    s = pick_live_slot();
    g = slot_gen[s];
    issue_cmd(mk_item(CMD_DESTROY, IDX_W'(s), g));
    issue_cmd(mk_item(CMD_QUERY, IDX_W'(s), g));
    issue_cmd(mk_item(CMD_CREATE, '0, '0));
    issue_cmd(mk_item(CMD_CREATE, '0, '0));
    issue_cmd(mk_item(CMD_QUERY, '1, slot_gen[SLOTS-1]));
    issue_cmd(mk_item(CMD_DESTROY, '1, slot_gen[SLOTS-1]));
    issue_cmd(mk_item(CMD_CREATE, '0, '0));
    issue_cmd(mk_item(CMD_CLEAR, '0, '0));
    drain_replies();
    repeat (3) issue_cmd(mk_item(CMD_CREATE, '1, '1));
    drain_replies();
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (handle_replies.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected result %p, none outstanding", $time, reply_item);
      end else begin
        want = handle_replies.pop_front();
        if (out_valid !== 1'b1 || reply_item.status !== want.status ||
            reply_item.out_index !== want.out_index ||
            reply_item.out_generation !== want.out_generation ||
            reply_item.alive !== want.alive || reply_item.live_count !== want.live_count) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: mismatch, expected st=%0d idx=%0d gen=%0d alive=%0d live=%0d, ",
                     $time, want.status, want.out_index, want.out_generation, want.alive,
                     want.live_count,
                     "actual st=%0d idx=%0d gen=%0d alive=%0d live=%0d",
                     reply_item.status, reply_item.out_index, reply_item.out_generation,
                     reply_item.alive, reply_item.live_count);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_slot_recycle();
    for (int c = 0; c < 3; c++) test_random_mix(40, c % 3 != 2);
    test_table_full();
    test_random_mix(40, 1'b0);
    repeat (40) @(posedge clk);
    if (bad_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* generational_handle_allocator.f */
design/gha_pkg.sv
design/gha_slot_ram.sv
design/generational_handle_allocator.sv
design/gha_checker.sv
test/testbench.sv
